/* hdl/client_handle_table_macros.svh */
// Assertion macros for the client handle table.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CLIENT_HANDLE_TABLE_MACROS_SVH
`define CLIENT_HANDLE_TABLE_MACROS_SVH
`ifndef SYNTH
`define CHT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("client_handle_table: check failed");
`define CHT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("client_handle_table: check failed");
`else
`define CHT_ASSERT(lbl, prop)
`define CHT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hdl/cht_pkg.sv */
// Shared types and constants for the client handle table.
// Used by cht_cell, cht_ctrl and client_handle_table; no dependencies.
package cht_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int CLIENT_W          = 8;
    localparam int NUMBER_W          = 32;
    localparam int REF_W             = 32;
    localparam int SLOT_W            = 6;
    localparam int FREED_W           = 7;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_FLUSH   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_IN_USE    = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [CLIENT_W-1:0] client_id;
        logic [NUMBER_W-1:0] handle_number;
        logic [REF_W-1:0]    node_ref;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [REF_W-1:0]   found_ref;
        logic [FREED_W-1:0] freed_count;
    } resp_t;

    typedef struct packed {
        logic [NUMBER_W-1:0] handle_number;
        logic [CLIENT_W-1:0] client_id;
        logic [REF_W-1:0]    node_ref;
    } entry_t;

    typedef struct packed {
        logic   shift;
        entry_t feed;
    } ring_ctl_t;

endpackage

/* hdl/cht_cell.sv */
// One table entry of the rotating ring; loads its neighbor's entry on shift.
// Depends on cht_pkg for the entry type.
module cht_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  cht_pkg::entry_t d,
    output cht_pkg::entry_t q
);

    cht_pkg::entry_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

/* hdl/cht_ctrl.sv */
// Sequencer at the head of the ring: scans entries as they pass, edits them,
// and builds the response. Depends on cht_pkg and client_handle_table_macros.svh.
`include "client_handle_table_macros.svh"

module cht_ctrl #(
    parameter int TABLE_ENTRIES = cht_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cht_pkg::req_t        req,
    output logic                 done,
    output cht_pkg::resp_t       resp,
    input  cht_pkg::entry_t      head,
    output cht_pkg::ring_ctl_t   ring_ctl
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W  = cht_pkg::SLOT_W;
    localparam int FREED_W = cht_pkg::FREED_W;

    cht_pkg::state_t state_reg, state_next;
    cht_pkg::req_t   req_reg, req_next;
    cht_pkg::resp_t  resp_reg, resp_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [cht_pkg::REF_W-1:0] fref_reg, fref_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic hit_reg, hit_next;
    logic free_found_reg, free_found_next;
    logic done_reg, done_next;
    logic last, match, owned, is_free, go_place;

    assign last    = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign is_free = (head.node_ref == '0);
    assign owned   = !is_free && (head.client_id == req_reg.client_id);
    assign match   = owned && (head.handle_number == req_reg.handle_number);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cht_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cht_pkg::ST_SCAN;
                end
            end
            cht_pkg::ST_SCAN:
            begin
                if (last)
                begin
                    state_next = go_place ? cht_pkg::ST_PLACE : cht_pkg::ST_IDLE;
                end
            end
            cht_pkg::ST_PLACE:
            begin
                if (last)
                begin
                    state_next = cht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cht_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ring_ctl.shift  = 1'b0;
        ring_ctl.feed   = head;
        req_next        = req_reg;
        resp_next       = resp_reg;
        idx_next        = idx_reg;
        free_slot_next  = free_slot_reg;
        slot_next       = slot_reg;
        fref_next       = fref_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        done_next       = 1'b0;
        go_place        = 1'b0;
        unique case (state_reg)
            cht_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next        = req;
                    idx_next        = '0;
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            cht_pkg::ST_SCAN:
            begin
                ring_ctl.shift = 1'b1;
                idx_next = last ? '0 : idx_reg + 1'b1;
                unique case (req_reg.cmd)
                    cht_pkg::CMD_ALLOC:
                    begin
                        if (match)
                        begin
                            hit_next = 1'b1;
                        end
                        if (is_free && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_slot_next  = idx_reg;
                        end
                    end
                    cht_pkg::CMD_LOOKUP:
                    begin
                        if (match && !hit_reg)
                        begin
                            hit_next  = 1'b1;
                            slot_next = idx_reg;
                            fref_next = head.node_ref;
                        end
                    end
                    cht_pkg::CMD_RELEASE:
                    begin
                        if (match && !hit_reg)
                        begin
                            hit_next  = 1'b1;
                            slot_next = idx_reg;
                            ring_ctl.feed.node_ref  = '0;
                            ring_ctl.feed.client_id = '0;
                        end
                    end
                    cht_pkg::CMD_FLUSH:
                    begin
                        if (owned)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            ring_ctl.feed.node_ref  = '0;
                            ring_ctl.feed.client_id = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (last)
                begin
                    go_place = (req_reg.cmd == cht_pkg::CMD_ALLOC) && !hit_next
                               && free_found_next;
                    if (!go_place)
                    begin
                        done_next = 1'b1;
                        resp_next = '0;
                        unique case (req_reg.cmd)
                            cht_pkg::CMD_ALLOC:
                            begin
                                resp_next.status = hit_next ? cht_pkg::STAT_IN_USE
                                                            : cht_pkg::STAT_FULL;
                            end
                            cht_pkg::CMD_LOOKUP:
                            begin
                                if (hit_next)
                                begin
                                    resp_next.slot      = SLOT_W'(slot_next);
                                    resp_next.found_ref = fref_next;
                                end
                                else
                                begin
                                    resp_next.status = cht_pkg::STAT_NOT_FOUND;
                                end
                            end
                            cht_pkg::CMD_RELEASE:
                            begin
                                if (hit_next)
                                begin
                                    resp_next.slot = SLOT_W'(slot_next);
                                end
                                else
                                begin
                                    resp_next.status = cht_pkg::STAT_NOT_FOUND;
                                end
                            end
                            cht_pkg::CMD_FLUSH:
                            begin
                                resp_next.freed_count = FREED_W'(cnt_next);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            cht_pkg::ST_PLACE:
            begin
                ring_ctl.shift = 1'b1;
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (idx_reg == free_slot_reg)
                begin
                    ring_ctl.feed.handle_number = req_reg.handle_number;
                    ring_ctl.feed.client_id     = req_reg.client_id;
                    ring_ctl.feed.node_ref      = req_reg.node_ref;
                end
                if (last)
                begin
                    done_next      = 1'b1;
                    resp_next      = '0;
                    resp_next.slot = SLOT_W'(free_slot_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cht_pkg::ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        resp_reg      <= resp_next;
        free_slot_reg <= free_slot_next;
        slot_reg      <= slot_next;
        fref_reg      <= fref_next;
    end

    assign busy = (state_reg != cht_pkg::ST_IDLE);
    assign done = done_reg;
    assign resp = resp_reg;

    `CHT_ASSERT(a_done_after_pass, done_reg |-> state_reg == cht_pkg::ST_IDLE)
    `CHT_ASSERT(a_place_only_free_alloc, state_reg == cht_pkg::ST_PLACE |-> req_reg.cmd == cht_pkg::CMD_ALLOC && !hit_reg && free_found_reg)
    `CHT_ASSERT(a_pass_starts_at_zero, $rose(busy) |-> idx_reg == '0)
    `CHT_ASSERT(a_lookup_ref_nonzero, done_reg && resp_reg.status == cht_pkg::STAT_OK && req_reg.cmd == cht_pkg::CMD_LOOKUP |-> resp_reg.found_ref != '0)
    `CHT_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !busy && !done)

endmodule

/* hdl/client_handle_table.sv */
// Client handle table top level: a ring of entry cells and a head sequencer.
// Depends on cht_pkg, cht_cell and cht_ctrl.
//
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at a
//   rising edge with start high and busy low. busy stays high while the table
//   scans and falls when the response is ready.
//   Response channel: resp is valid for exactly one cycle while done is high.
//   The receiver cannot stall; it must take resp in that cycle.
// Passes:
//   Entries rotate through the ring one cell per cycle while busy is high, the
//   sequencer sees each entry once at the ring head, so a pass visits all TABLE_ENTRIES entries.
//   Lookup, release, flush and a failed allocate take one pass, at the end of
//   which done rises after the accepting edge. A successful allocate adds a
//   second pass to write the chosen free entry.
//   A new request is taken in the cycle done is high.
// Reset:
//   rst_n clears every entry's reference, so the table starts empty, and
//   returns the sequencer to idle; no clearing pass is needed.
module client_handle_table #(
    parameter int TABLE_ENTRIES = cht_pkg::DEF_TABLE_ENTRIES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cht_pkg::req_t  req,
    output logic           done,
    output cht_pkg::resp_t resp
);

    cht_pkg::entry_t    ring_q [TABLE_ENTRIES];
    cht_pkg::ring_ctl_t ring_ctl;

    genvar i;
    generate
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin : g_cell
            if (i == TABLE_ENTRIES - 1)
            begin : g_tail
                cht_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_ctl.shift),
                    .d     (ring_ctl.feed),
                    .q     (ring_q[i])
                );
            end
            else
            begin : g_body
                cht_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_ctl.shift),
                    .d     (ring_q[i+1]),
                    .q     (ring_q[i])
                );
            end
        end
    endgenerate

    cht_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .resp     (resp),
        .head     (ring_q[0]),
        .ring_ctl (ring_ctl)
    );

endmodule

/* dv/cht_tb_pkg.sv */
// Scoreboard for the client handle table testbench: predicts each response from
// its own copy of the table and checks the responses that the block returns.
// Depends on cht_pkg for the transaction, command and status types.
package cht_tb_pkg;

    import cht_pkg::*;

    localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;

    class handle_table_checker;

        logic [NUMBER_W-1:0] tbl_number[TABLE_ENTRIES];
        logic [CLIENT_W-1:0] tbl_client[TABLE_ENTRIES];
        logic [REF_W-1:0]    tbl_ref[TABLE_ENTRIES];
        resp_t               expected_resp[$];
        int                  fail_count;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_number[i] = '0;
                tbl_client[i] = '0;
                tbl_ref[i]    = '0;
            end
            fail_count = 0;
        endfunction

        function resp_t predict_response(req_t r);
            resp_t res;
            int    hit;
            int    free_idx;
            int    freed;
            res      = '0;
            res.status = STAT_OK;
            hit      = -1;
            free_idx = -1;
            freed    = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (hit < 0 && tbl_ref[i] != '0 && tbl_client[i] == r.client_id &&
                    tbl_number[i] == r.handle_number)
                    hit = i;
                if (free_idx < 0 && tbl_ref[i] == '0)
                    free_idx = i;
            end
            case (r.cmd)
                CMD_ALLOC:
                begin
                    if (hit >= 0)
                        res.status = STAT_IN_USE;
                    else if (free_idx < 0)
                        res.status = STAT_FULL;
                    else
                    begin
                        tbl_number[free_idx] = r.handle_number;
                        tbl_client[free_idx] = r.client_id;
                        tbl_ref[free_idx]    = r.node_ref;
                        res.slot             = free_idx[SLOT_W-1:0];
                    end
                end
                CMD_LOOKUP:
                begin
                    if (hit < 0)
                        res.status = STAT_NOT_FOUND;
                    else
                    begin
                        res.slot      = hit[SLOT_W-1:0];
                        res.found_ref = tbl_ref[hit];
                    end
                end
                CMD_RELEASE:
                begin
                    if (hit < 0)
                        res.status = STAT_NOT_FOUND;
                    else
                    begin
                        tbl_ref[hit]    = '0;
                        tbl_client[hit] = '0;
                        res.slot        = hit[SLOT_W-1:0];
                    end
                end
                default:
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (tbl_ref[i] != '0 && tbl_client[i] == r.client_id)
                        begin
                            tbl_ref[i]    = '0;
                            tbl_client[i] = '0;
                            freed++;
                        end
                    end
                end
            endcase
            res.freed_count = freed[FREED_W-1:0];
            return res;
        endfunction

        function void note_request(req_t r);
            expected_resp.push_back(predict_response(r));
        endfunction

        function void check_response(resp_t got);
            resp_t want;
            if (expected_resp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response: status=%0d slot=%0d ref=%h freed=%0d",
                             got.status, got.slot, got.found_ref, got.freed_count);
                return;
            end
            want = expected_resp.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.found_ref !== want.found_ref || got.freed_count !== want.freed_count)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("response mismatch: expected status=%0d slot=%0d ref=%h freed=%0d",
                             want.status, want.slot, want.found_ref, want.freed_count);
                    $display("                   actual   status=%0d slot=%0d ref=%h freed=%0d",
                             got.status, got.slot, got.found_ref, got.freed_count);
                end
            end
        endfunction

        function int pick_live_slot();
            int live[$];
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (tbl_ref[i] != '0)
                    live.push_back(i);
            if (live.size() == 0)
                return -1;
            return live[$urandom_range(live.size() - 1)];
        endfunction

    endclass

endpackage

/* dv/tb_top.sv */
// Top-level testbench for client_handle_table: directed and random command
// transactions with random sender gaps, responses checked by the scoreboard.
// Depends on cht_pkg, cht_tb_pkg and the client_handle_table RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;
    import cht_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    resp_t resp;

    handle_table_checker sb = new();
    int send_idle_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;

    client_handle_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .resp  (resp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_response(resp);

    function automatic req_t make_req(cmd_t c, logic [CLIENT_W-1:0] cl,
                                      logic [NUMBER_W-1:0] num, logic [REF_W-1:0] nr);
        req_t r;
        r.cmd           = c;
        r.client_id     = cl;
        r.handle_number = num;
        r.node_ref      = nr;
        return r;
    endfunction

    task automatic send(input req_t r);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 2 * TABLE_ENTRIES + 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.note_request(r);
        items_sent++;
    endtask

    // empty the table, fill it with one client, hit it when full, then flush it
    task automatic fill_and_flush();
        int                  s;
        logic [CLIENT_W-1:0] cl;
        logic [NUMBER_W-1:0] base;
        logic [REF_W-1:0]    nr;
        s = sb.pick_live_slot();
        while (s >= 0)
        begin
            send(make_req(CMD_FLUSH, sb.tbl_client[s], $urandom(), $urandom()));
            s = sb.pick_live_slot();
        end
        cl   = CLIENT_W'($urandom_range(255));
        base = $urandom();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            nr = $urandom();
            if (nr == '0)
                nr = 32'h1;
            send(make_req(CMD_ALLOC, cl, base + i, nr));
        end
        send(make_req(CMD_ALLOC, cl, base, $urandom()));
        send(make_req(CMD_ALLOC, cl, base - 1, 32'hFFFF_FFFF));
        send(make_req(CMD_LOOKUP, cl, base + TABLE_ENTRIES - 1, $urandom()));
        send(make_req(CMD_FLUSH, cl, $urandom(), $urandom()));
    endtask

    task automatic run_phase(input int idle_pct, input int count);
        int                  stop_at;
        int                  roll;
        int                  s;
        bit                  use_held;
        cmd_t                c;
        logic [CLIENT_W-1:0] cl;
        logic [NUMBER_W-1:0] num;
        logic [REF_W-1:0]    nr;
        send_idle_pct = idle_pct;
        stop_at = items_sent + count;
        fill_and_flush();
        while (items_sent < stop_at)
        begin
            if ($urandom_range(999) < 3)
                fill_and_flush();
            else
            begin
                roll = $urandom_range(99);
                s = sb.pick_live_slot();
                case ($urandom_range(5))
                    0:       cl = 8'h00;
                    1:       cl = 8'hFF;
                    2:       cl = 8'h01;
                    3:       cl = 8'h02;
                    default: cl = CLIENT_W'($urandom_range(255));
                endcase
                case ($urandom_range(6))
                    0:       num = '0;
                    1:       num = '1;
                    2:       num = 32'h8000_0000;
                    3, 4:    num = $urandom_range(7);
                    default: num = $urandom();
                endcase
                nr = $urandom();
                if ($urandom_range(99) < 4)
                    nr = '0;
                use_held = (s >= 0) && ($urandom_range(99) < (roll < 45 ? 15 : 80));
                if (use_held)
                begin
                    cl  = sb.tbl_client[s];
                    num = sb.tbl_number[s];
                end
                if (roll < 45)
                    c = CMD_ALLOC;
                else if (roll < 70)
                    c = CMD_LOOKUP;
                else if (roll < 93)
                    c = CMD_RELEASE;
                else
                    c = CMD_FLUSH;
                send(make_req(c, cl, num, nr));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        send(make_req(CMD_LOOKUP,  8'h00, 32'h0000_0000, 32'h0000_0000));
        send(make_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF));
        send(make_req(CMD_FLUSH,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000));
        send(make_req(CMD_ALLOC,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_req(CMD_ALLOC,   8'hFF, 32'hFFFF_FFFF, 32'h1234_5678));
        send(make_req(CMD_ALLOC,   8'h00, 32'h0000_0000, 32'h0000_0001));
        send(make_req(CMD_ALLOC,   8'h12, 32'h0000_0005, 32'h0000_0000));
        send(make_req(CMD_LOOKUP,  8'h12, 32'h0000_0005, 32'h0000_0000));
        send(make_req(CMD_ALLOC,   8'h12, 32'h0000_0006, 32'hA5A5_A5A5));
        send(make_req(CMD_LOOKUP,  8'hFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send(make_req(CMD_ALLOC,   8'hFF, 32'h0000_0000, 32'h8000_0000));
        send(make_req(CMD_ALLOC,   8'h00, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send(make_req(CMD_ALLOC,   8'h01, 32'h0000_0007, 32'h5A5A_5A5A));
        send(make_req(CMD_ALLOC,   8'h02, 32'h0000_0007, 32'hC3C3_C3C3));
        send(make_req(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send(make_req(CMD_LOOKUP,  8'hFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send(make_req(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send(make_req(CMD_ALLOC,   8'h7F, 32'h8000_0000, 32'h0000_0002));
        send(make_req(CMD_LOOKUP,  8'h02, 32'h0000_0007, 32'h0000_0000));
        send(make_req(CMD_FLUSH,   8'hFF, 32'h0000_0000, 32'h0000_0000));
        send(make_req(CMD_FLUSH,   8'h00, 32'h0000_0000, 32'h0000_0000));
        send(make_req(CMD_RELEASE, 8'h12, 32'h0000_0006, 32'h0000_0000));
        send(make_req(CMD_LOOKUP,  8'h7F, 32'h8000_0000, 32'h0000_0000));
        send(make_req(CMD_FLUSH,   8'h7F, 32'h0000_0000, 32'h0000_0000));

        run_phase(9, 383);
        run_phase(53, 383);
        run_phase(0, 384);

        start <= 1'b0;
        while (sb.expected_resp.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);

        if (sb.fail_count == 0 && sb.expected_resp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
